// File: sv/irrd_pkg.sv
// shared types, constants and reset values for the id range ring dispenser
package irrd_pkg;

	localparam int RING_DEPTH = 16;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int ID_W       = 63;
	localparam int SLOT_W     = 2 * ID_W;
	localparam int BATCH_W    = 31;
	localparam int MINB_W     = 21;
	localparam int FACT_W     = 5;
	localparam int WORD_W     = 32;
	localparam int LW_W       = 8;
	localparam int GPROD_W    = BATCH_W + FACT_W;
	localparam int TPROD_W    = 2 * WORD_W;
	localparam int CFG_IDX_W  = 3;

	localparam logic [MINB_W-1:0]  MIN_BATCH_RST   = 21'd100;
	localparam logic [BATCH_W-1:0] MAX_BATCH_RST   = 31'd1000000;
	localparam logic [FACT_W-1:0]  GROWTH_FACT_RST = 5'd2;
	localparam logic [WORD_W-1:0]  GROWTH_INTV_RST = 32'd1000000;
	localparam logic [WORD_W-1:0]  TIMEOUT_BASE_RST = 32'd100000;
	localparam logic [WORD_W-1:0]  TIMEOUT_CAP_RST = 32'd3000000;
	localparam logic [LW_W-1:0]    LOW_WATER_RST   = 8'd2;

	typedef enum logic [1:0] {
		FN_GET  = 2'd0,
		FN_FILL = 2'd1,
		FN_FAIL = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_BATCH    = 3'd0,
		REG_MAX_BATCH    = 3'd1,
		REG_GROWTH_FACT  = 3'd2,
		REG_GROWTH_INTV  = 3'd3,
		REG_TIMEOUT_BASE = 3'd4,
		REG_TIMEOUT_CAP  = 3'd5,
		REG_LOW_WATER    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic cap;
		logic rd;
		logic take;
		logic none;
		logic adv;
		logic fill;
		logic req;
		logic grow;
		logic fin;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       hit;
		logic       empty;
	} dp_stat_t;

endpackage

// File: sv/irrd_ram.sv
// generic single write port ram with registered read
module irrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// File: sv/irrd_ctrl.sv
// controller state machine sequencing read, check, request, grow and finish steps
module irrd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  irrd_pkg::dp_stat_t st,
	output irrd_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_CHK  = 6'b000100,
		S_REQ  = 6'b001000,
		S_GROW = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_nx;
	logic   done_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.cap = start;
				if (start) begin
					state_nx = S_RD;
				end
			end
			S_RD: begin
				cmd.rd   = 1'b1;
				state_nx = S_CHK;
			end
			S_CHK: begin
				case (st.func)
					irrd_pkg::FN_GET: begin
						if (st.hit) begin
							cmd.take = 1'b1;
							state_nx = S_REQ;
						end else if (st.empty) begin
							cmd.none = 1'b1;
							state_nx = S_REQ;
						end else begin
							cmd.adv  = 1'b1;
							state_nx = S_RD;
						end
					end
					irrd_pkg::FN_FILL: begin
						cmd.fill = 1'b1;
						state_nx = S_FIN;
					end
					default: begin
						state_nx = S_FIN;
					end
				endcase
			end
			S_REQ: begin
				cmd.req  = 1'b1;
				state_nx = S_GROW;
			end
			S_GROW: begin
				cmd.grow = 1'b1;
				state_nx = S_FIN;
			end
			S_FIN: begin
				cmd.fin  = 1'b1;
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == S_FIN);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// File: sv/irrd_dp.sv
// datapath: config registers, slot ring, counters, batch and timeout arithmetic
module irrd_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  irrd_pkg::dp_cmd_t                     cmd,
	output irrd_pkg::dp_stat_t                    st,
	input  logic                                  cfg_we,
	input  logic [irrd_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [irrd_pkg::WORD_W-1:0]           cfg_data,
	input  logic [1:0]                            func,
	input  logic [irrd_pkg::ID_W-1:0]             range_start,
	input  logic [irrd_pkg::ID_W-1:0]             range_end,
	input  logic [irrd_pkg::ID_W-1:0]             now_time,
	input  logic                                  renew_hint,
	output logic [irrd_pkg::ID_W-1:0]             id_value,
	output logic                                  id_valid,
	output logic                                  no_id,
	output logic                                  fetch_request,
	output logic [irrd_pkg::BATCH_W-1:0]          fetch_count,
	output logic [irrd_pkg::WORD_W-1:0]           fetch_timeout,
	output logic                                  fetch_force,
	output logic                                  range_dropped
);

	// config registers
	logic [irrd_pkg::MINB_W-1:0]  minb_q;
	logic [irrd_pkg::BATCH_W-1:0] maxb_q;
	logic [irrd_pkg::FACT_W-1:0]  fact_q;
	logic [irrd_pkg::WORD_W-1:0]  intv_q;
	logic [irrd_pkg::WORD_W-1:0]  tbase_q;
	logic [irrd_pkg::WORD_W-1:0]  tcap_q;
	logic [irrd_pkg::LW_W-1:0]    lw_q;

	// captured word
	logic [1:0]                  func_q;
	logic [irrd_pkg::ID_W-1:0]   start_q;
	logic [irrd_pkg::ID_W-1:0]   end_q;
	logic [irrd_pkg::ID_W-1:0]   now_q;
	logic                        force_q;

	// ring and request state
	logic [irrd_pkg::PTR_W-1:0]      rd_ptr_q;
	logic [irrd_pkg::PTR_W-1:0]      wr_ptr_q;
	logic [irrd_pkg::PTR_W-1:0]      unr_q;
	logic [irrd_pkg::LW_W-1:0]       fc_q;
	logic [irrd_pkg::RING_DEPTH-1:0] vld_q;
	logic                            rd_vld_q;
	logic                            pend_q;
	logic [irrd_pkg::WORD_W-1:0]     retry_q;
	logic [irrd_pkg::BATCH_W-1:0]    batch_q;
	logic [irrd_pkg::ID_W-1:0]       last_q;
	logic                            grow_q;
	logic [irrd_pkg::TPROD_W-1:0]    tprod_q;
	logic [irrd_pkg::GPROD_W-1:0]    gprod_q;

	// result word
	logic [irrd_pkg::ID_W-1:0]    idv_q;
	logic                         idok_q;
	logic                         noid_q;
	logic                         freq_q;
	logic [irrd_pkg::BATCH_W-1:0] fcnt_q;
	logic [irrd_pkg::WORD_W-1:0]  ftmo_q;
	logic                         ffrc_q;
	logic                         drop_q;

	logic [irrd_pkg::PTR_W-1:0]  slot_addr;
	logic [irrd_pkg::SLOT_W-1:0] ram_rdata;
	logic [irrd_pkg::SLOT_W-1:0] ram_wdata;
	logic                        ram_we;
	logic [irrd_pkg::ID_W-1:0]   slot_nxt;
	logic [irrd_pkg::ID_W-1:0]   slot_lim;
	logic                        ring_full;
	logic [irrd_pkg::LW_W-1:0]   unr_ext;
	logic                        req_cond;
	logic                        grow_cond;
	logic [irrd_pkg::WORD_W-1:0] retry_mul;
	logic [irrd_pkg::BATCH_W-1:0] minb_ext;
	logic [irrd_pkg::BATCH_W-1:0] batch_shr;
	logic [irrd_pkg::PTR_W-1:0]  rd_ptr_inc;
	logic [irrd_pkg::PTR_W-1:0]  wr_ptr_inc;

	assign slot_addr = (func_q == irrd_pkg::FN_FILL) ? wr_ptr_q : rd_ptr_q;
	assign slot_nxt  = rd_vld_q ? ram_rdata[irrd_pkg::SLOT_W-1:irrd_pkg::ID_W] : '0;
	assign slot_lim  = rd_vld_q ? ram_rdata[irrd_pkg::ID_W-1:0] : '0;
	assign ring_full = (unr_q >= irrd_pkg::PTR_W'(irrd_pkg::RING_DEPTH - 1));
	assign unr_ext   = irrd_pkg::LW_W'(unr_q);
	assign req_cond  = (unr_ext < lw_q) && !pend_q;
	assign grow_cond = (unr_ext <= (lw_q >> 1)) && (fc_q >= lw_q) && (now_q > last_q)
		&& ((now_q - last_q) > irrd_pkg::ID_W'(intv_q));
	assign retry_mul = (retry_q == '0) ? irrd_pkg::WORD_W'(1) : retry_q;
	assign minb_ext  = irrd_pkg::BATCH_W'(minb_q);
	assign batch_shr = (batch_q >= irrd_pkg::BATCH_W'({minb_q, 1'b0})) ?
		(batch_q - minb_ext) : minb_ext;
	assign rd_ptr_inc = (rd_ptr_q == irrd_pkg::PTR_W'(irrd_pkg::RING_DEPTH - 1)) ?
		'0 : (rd_ptr_q + 1'b1);
	assign wr_ptr_inc = (wr_ptr_q == irrd_pkg::PTR_W'(irrd_pkg::RING_DEPTH - 1)) ?
		'0 : (wr_ptr_q + 1'b1);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {slot_nxt + 1'b1, slot_lim};
		if (cmd.take) begin
			ram_we = 1'b1;
		end else if (cmd.fill && !ring_full) begin
			ram_we    = 1'b1;
			ram_wdata = {((start_q > slot_nxt) ? start_q : slot_nxt),
				((end_q > slot_lim) ? end_q : slot_lim)};
		end
	end

	assign st.func  = func_q;
	assign st.hit   = (slot_nxt < slot_lim);
	assign st.empty = (unr_q == '0);

	irrd_ram #(
		.WIDTH (irrd_pkg::SLOT_W),
		.DEPTH (irrd_pkg::RING_DEPTH)
	) u_slot_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (slot_addr),
		.wdata   (ram_wdata),
		.re      (cmd.rd),
		.raddr   (slot_addr),
		.rdata_q (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minb_q  <= irrd_pkg::MIN_BATCH_RST;
			maxb_q  <= irrd_pkg::MAX_BATCH_RST;
			fact_q  <= irrd_pkg::GROWTH_FACT_RST;
			intv_q  <= irrd_pkg::GROWTH_INTV_RST;
			tbase_q <= irrd_pkg::TIMEOUT_BASE_RST;
			tcap_q  <= irrd_pkg::TIMEOUT_CAP_RST;
			lw_q    <= irrd_pkg::LOW_WATER_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				irrd_pkg::REG_MIN_BATCH:    minb_q  <= cfg_data[irrd_pkg::MINB_W-1:0];
				irrd_pkg::REG_MAX_BATCH:    maxb_q  <= cfg_data[irrd_pkg::BATCH_W-1:0];
				irrd_pkg::REG_GROWTH_FACT:  fact_q  <= cfg_data[irrd_pkg::FACT_W-1:0];
				irrd_pkg::REG_GROWTH_INTV:  intv_q  <= cfg_data;
				irrd_pkg::REG_TIMEOUT_BASE: tbase_q <= cfg_data;
				irrd_pkg::REG_TIMEOUT_CAP:  tcap_q  <= cfg_data;
				irrd_pkg::REG_LOW_WATER:    lw_q    <= cfg_data[irrd_pkg::LW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q  <= func;
			start_q <= range_start;
			end_q   <= range_end;
			now_q   <= now_time;
			force_q <= renew_hint;
		end
		if (cmd.rd) begin
			rd_vld_q <= vld_q[slot_addr];
		end
		if (cmd.req) begin
			tprod_q <= irrd_pkg::TPROD_W'(tbase_q) * irrd_pkg::TPROD_W'(retry_mul);
		end
		if (cmd.grow) begin
			gprod_q <= irrd_pkg::GPROD_W'(batch_q) * irrd_pkg::GPROD_W'(fact_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			unr_q    <= '0;
			fc_q     <= '0;
			vld_q    <= '0;
			pend_q   <= 1'b0;
			retry_q  <= '0;
			batch_q  <= irrd_pkg::BATCH_W'(irrd_pkg::MIN_BATCH_RST);
			last_q   <= '0;
			grow_q   <= 1'b0;
			idv_q    <= '0;
			idok_q   <= 1'b0;
			noid_q   <= 1'b0;
			freq_q   <= 1'b0;
			fcnt_q   <= '0;
			ftmo_q   <= '0;
			ffrc_q   <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			if (ram_we) begin
				vld_q[slot_addr] <= 1'b1;
			end
			if (cmd.cap) begin
				grow_q <= 1'b0;
				idv_q  <= '0;
				idok_q <= 1'b0;
				noid_q <= 1'b0;
				freq_q <= 1'b0;
				fcnt_q <= '0;
				ftmo_q <= '0;
				ffrc_q <= 1'b0;
				drop_q <= 1'b0;
			end
			if (cmd.take) begin
				idv_q  <= slot_nxt;
				idok_q <= 1'b1;
			end
			if (cmd.none) begin
				noid_q <= 1'b1;
			end
			if (cmd.adv) begin
				rd_ptr_q <= rd_ptr_inc;
				unr_q    <= unr_q - 1'b1;
			end
			if (cmd.fill) begin
				pend_q <= 1'b0;
				if (ring_full) begin
					drop_q <= 1'b1;
				end else begin
					wr_ptr_q <= wr_ptr_inc;
					unr_q    <= unr_q + 1'b1;
					retry_q  <= '0;
					if (fc_q != '1) begin
						fc_q <= fc_q + 1'b1;
					end
				end
			end
			if (cmd.req && req_cond) begin
				pend_q  <= 1'b1;
				freq_q  <= 1'b1;
				fcnt_q  <= batch_q;
				ffrc_q  <= force_q;
				batch_q <= batch_shr;
				grow_q  <= grow_cond;
				if (retry_q != '1) begin
					retry_q <= retry_q + 1'b1;
				end
			end
			if (cmd.grow && freq_q) begin
				ftmo_q <= (tprod_q > irrd_pkg::TPROD_W'(tcap_q)) ?
					tcap_q : tprod_q[irrd_pkg::WORD_W-1:0];
			end
			if (cmd.fin) begin
				if (grow_q) begin
					batch_q <= (gprod_q > irrd_pkg::GPROD_W'(maxb_q)) ?
						maxb_q : gprod_q[irrd_pkg::BATCH_W-1:0];
					last_q  <= now_q;
				end
				if (func_q == irrd_pkg::FN_FAIL) begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	assign id_value      = idv_q;
	assign id_valid      = idok_q;
	assign no_id         = noid_q;
	assign fetch_request = freq_q;
	assign fetch_count   = fcnt_q;
	assign fetch_timeout = ftmo_q;
	assign fetch_force   = ffrc_q;
	assign range_dropped = drop_q;

endmodule

// File: sv/id_range_ring_dispenser.sv
// top level of the id range ring dispenser
//
// usage: a word is taken at a rising edge with start high and busy low.
// func selects get, fill or fetch failed; range_start and range_end give a
// filled range; now_time stamps the word for batch growth throttling and
// renew_hint rides along with any refill request raised by a get.
// every word gives exactly one result, shown on the result ports for one
// cycle with done high; the receiver has no way to hold it off.
// fill, fetch failed and unused codes step through read, check and finish;
// a get steps through read, check, request, grow and finish, with one more
// read and check for every exhausted slot skipped, one slot at a time
// through the single read port of the slot ram. busy stays high until the
// done cycle, in which a new word may already be taken.
// config registers are written through cfg_we, cfg_idx and cfg_data at any
// edge, meant for idle periods; an index past the register list is ignored.
// reset clears the ring, counters and pending request and puts the config
// registers and the batch size back to their defaults.
module id_range_ring_dispenser (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	output logic                                  done,
	input  logic                                  cfg_we,
	input  logic [irrd_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [irrd_pkg::WORD_W-1:0]           cfg_data,
	input  logic [1:0]                            func,
	input  logic [irrd_pkg::ID_W-1:0]             range_start,
	input  logic [irrd_pkg::ID_W-1:0]             range_end,
	input  logic [irrd_pkg::ID_W-1:0]             now_time,
	input  logic                                  renew_hint,
	output logic [irrd_pkg::ID_W-1:0]             id_value,
	output logic                                  id_valid,
	output logic                                  no_id,
	output logic                                  fetch_request,
	output logic [irrd_pkg::BATCH_W-1:0]          fetch_count,
	output logic [irrd_pkg::WORD_W-1:0]           fetch_timeout,
	output logic                                  fetch_force,
	output logic                                  range_dropped
);

	irrd_pkg::dp_cmd_t  cmd;
	irrd_pkg::dp_stat_t st;

	irrd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	irrd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.func          (func),
		.range_start   (range_start),
		.range_end     (range_end),
		.now_time      (now_time),
		.renew_hint    (renew_hint),
		.id_value      (id_value),
		.id_valid      (id_valid),
		.no_id         (no_id),
		.fetch_request (fetch_request),
		.fetch_count   (fetch_count),
		.fetch_timeout (fetch_timeout),
		.fetch_force   (fetch_force),
		.range_dropped (range_dropped)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done shown while still busy");

	a_id_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(id_valid && no_id))
		else $error("id and no id flagged together");

	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_dropped) |-> (!id_valid && !fetch_request))
		else $error("dropped fill carried get results");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.none, cmd.adv, cmd.fill}))
		else $error("conflicting slot commands");

endmodule

// File: tb/sv/id_range_ring_dispenser_tb.sv
// self-checking testbench for the id range ring dispenser
`timescale 1ns / 1ps

module id_range_ring_dispenser_tb;
	import irrd_pkg::*;

	localparam logic [1:0]           FN_UNUSED     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
	localparam logic [ID_W-1:0]      ID_MAX        = {ID_W{1'b1}};
	localparam int                   QUIET_LIMIT   = 600;

	typedef struct packed {
		logic [1:0]      fn;
		logic [ID_W-1:0] lo;
		logic [ID_W-1:0] hi;
		logic [ID_W-1:0] stamp;
		logic            renew;
	} word_t;

	typedef struct packed {
		logic [ID_W-1:0]    id_value;
		logic               id_valid;
		logic               no_id;
		logic               fetch_request;
		logic [BATCH_W-1:0] fetch_count;
		logic [WORD_W-1:0]  fetch_timeout;
		logic               fetch_force;
		logic               range_dropped;
	} outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 done;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [WORD_W-1:0]    cfg_data = '0;
	logic [1:0]           func = '0;
	logic [ID_W-1:0]      range_start = '0;
	logic [ID_W-1:0]      range_end = '0;
	logic [ID_W-1:0]      now_time = '0;
	logic                 renew_hint = 1'b0;
	logic [ID_W-1:0]      id_value;
	logic                 id_valid;
	logic                 no_id;
	logic                 fetch_request;
	logic [BATCH_W-1:0]   fetch_count;
	logic [WORD_W-1:0]    fetch_timeout;
	logic                 fetch_force;
	logic                 range_dropped;

	id_range_ring_dispenser uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.func(func),
		.range_start(range_start),
		.range_end(range_end),
		.now_time(now_time),
		.renew_hint(renew_hint),
		.id_value(id_value),
		.id_valid(id_valid),
		.no_id(no_id),
		.fetch_request(fetch_request),
		.fetch_count(fetch_count),
		.fetch_timeout(fetch_timeout),
		.fetch_force(fetch_force),
		.range_dropped(range_dropped)
	);

	// mirror of the dispenser state and registers
	logic [ID_W-1:0]    ring_next [RING_DEPTH];
	logic [ID_W-1:0]    ring_lim [RING_DEPTH];
	logic [63:0]        rd_cnt, wr_cnt, batch;
	logic               req_open;
	logic [WORD_W-1:0]  retries;
	logic [ID_W-1:0]    grown_at;
	logic [MINB_W-1:0]  cf_min;
	logic [BATCH_W-1:0] cf_max;
	logic [FACT_W-1:0]  cf_fact;
	logic [WORD_W-1:0]  cf_intv, cf_tbase, cf_tcap;
	logic [LW_W-1:0]    cf_lw;

	word_t    pending_words[$];
	outcome_t due_outcomes[$];
	word_t    cur = '0;
	logic     presenting = 1'b0;
	logic     word_taken = 1'b0;
	logic     idle_on = 1'b1;
	logic     calm = 1'b0;
	int       gap_left = 0;
	int       quiet = 0;
	int       n_bad = 0, n_words = 0, n_results = 0, n_cfg = 0;
	int       n_ids = 0, n_none = 0, n_skip = 0, n_req = 0, n_grow = 0, n_drop = 0;
	logic [63:0] id_base = 64'd1000;
	logic [63:0] stamp_now = '0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic outcome_t dispense(input word_t w);
		outcome_t o;
		logic [PTR_W-1:0] s;
		logic [63:0] unread, tmo, prod;
		logic [WORD_W-1:0] r;
		logic looking;
		int g;
		o = '0;
		if (w.fn == FN_GET) begin
			looking = 1'b1;
			for (g = 0; g <= RING_DEPTH && looking; g++) begin
				s = rd_cnt[PTR_W-1:0];
				if (ring_next[s] < ring_lim[s]) begin
					o.id_value = ring_next[s];
					o.id_valid = 1'b1;
					ring_next[s] = ring_next[s] + 1'b1;
					looking = 1'b0;
					n_ids++;
				end else if (wr_cnt == rd_cnt) begin
					o.no_id = 1'b1;
					looking = 1'b0;
				end else begin
					rd_cnt++;
					n_skip++;
				end
			end
			if (looking)
				o.no_id = 1'b1;
			if (o.no_id)
				n_none++;
			unread = wr_cnt - rd_cnt;
			if (unread < 64'(cf_lw) && !req_open) begin
				r = (retries != 0) ? retries : 32'd1;
				tmo = 64'(cf_tbase) * 64'(r);
				if (tmo > 64'(cf_tcap))
					tmo = 64'(cf_tcap);
				req_open = 1'b1;
				if (retries != {WORD_W{1'b1}})
					retries++;
				o.fetch_request = 1'b1;
				o.fetch_count = batch[BATCH_W-1:0];
				o.fetch_timeout = tmo[WORD_W-1:0];
				o.fetch_force = w.renew;
				n_req++;
				if (batch >= 64'(cf_min) + 64'(cf_min))
					batch = batch - 64'(cf_min);
				else
					batch = 64'(cf_min);
				if (unread <= 64'(cf_lw >> 1) && wr_cnt >= 64'(cf_lw) && w.stamp > grown_at
						&& 64'(w.stamp - grown_at) > 64'(cf_intv)) begin
					prod = batch * 64'(cf_fact);
					if (prod > 64'(cf_max))
						prod = 64'(cf_max);
					batch = {33'd0, prod[BATCH_W-1:0]};
					grown_at = w.stamp;
					n_grow++;
				end
			end
		end else if (w.fn == FN_FILL) begin
			if (wr_cnt - rd_cnt >= 64'(RING_DEPTH - 1)) begin
				o.range_dropped = 1'b1;
				n_drop++;
			end else begin
				s = wr_cnt[PTR_W-1:0];
				if (w.lo > ring_next[s])
					ring_next[s] = w.lo;
				if (w.hi > ring_lim[s])
					ring_lim[s] = w.hi;
				wr_cnt++;
				retries = '0;
			end
			req_open = 1'b0;
		end else if (w.fn == FN_FAIL) begin
			req_open = 1'b0;
		end
		return o;
	endfunction

	// sender: one word at a time, random idle bursts after some accepted words
	always @(negedge clk) begin : feed
		if (word_taken) begin
			word_taken = 1'b0;
			presenting = 1'b0;
			if ($urandom_range(0, 29) == 0)
				calm = ~calm;
			if (idle_on && !calm && $urandom_range(0, 2) == 0)
				gap_left = $urandom_range(1, 13);
		end
		if (!presenting) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_words.size() != 0) begin
				cur = pending_words.pop_front();
				presenting = 1'b1;
			end
		end
		start <= presenting;
		func <= cur.fn;
		range_start <= cur.lo;
		range_end <= cur.hi;
		now_time <= cur.stamp;
		renew_hint <= cur.renew;
	end

	always @(posedge clk) begin : watch
		outcome_t got, want;
		if (arst_n) begin
			quiet++;
			if (done) begin
				quiet = 0;
				n_results++;
				got = {id_value, id_valid, no_id, fetch_request, fetch_count, fetch_timeout,
					fetch_force, range_dropped};
				if (due_outcomes.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected result at %0t: id %h req %b", $realtime, id_value,
							fetch_request);
				end else begin
					want = due_outcomes.pop_front();
					if (got !== want) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("mismatch on result %0d at %0t", n_results, $realtime);
							$display("  expected id %h v%b n%b req%b cnt %0d tmo %0d f%b drop %b",
								want.id_value, want.id_valid, want.no_id, want.fetch_request,
								want.fetch_count, want.fetch_timeout, want.fetch_force,
								want.range_dropped);
							$display("  actual   id %h v%b n%b req%b cnt %0d tmo %0d f%b drop %b",
								got.id_value, got.id_valid, got.no_id, got.fetch_request,
								got.fetch_count, got.fetch_timeout, got.fetch_force,
								got.range_dropped);
						end
					end
				end
			end
			if (start && !busy) begin
				quiet = 0;
				n_words++;
				due_outcomes.push_back(dispense(cur));
				word_taken = 1'b1;
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_MIN_BATCH:    cf_min = cfg_data[MINB_W-1:0];
					REG_MAX_BATCH:    cf_max = cfg_data[BATCH_W-1:0];
					REG_GROWTH_FACT:  cf_fact = cfg_data[FACT_W-1:0];
					REG_GROWTH_INTV:  cf_intv = cfg_data;
					REG_TIMEOUT_BASE: cf_tbase = cfg_data;
					REG_TIMEOUT_CAP:  cf_tcap = cfg_data;
					REG_LOW_WATER:    cf_lw = cfg_data[LW_W-1:0];
					default: ;
				endcase
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					quiet, due_outcomes.size());
				$display("id_range_ring_dispenser_tb: done, errors");
				$finish;
			end
		end
	end

	function automatic logic [ID_W-1:0] rand_id();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[ID_W-1:0];
	endfunction

	task automatic queue_word(input logic [1:0] fn, input logic [ID_W-1:0] lo,
			input logic [ID_W-1:0] hi, input logic [ID_W-1:0] stamp, input logic renew);
		word_t w;
		w.fn = fn;
		w.lo = lo;
		w.hi = hi;
		w.stamp = stamp;
		w.renew = renew;
		pending_words.push_back(w);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
	endtask

	task automatic program_all(input logic [WORD_W-1:0] mn, input logic [WORD_W-1:0] mx,
			input logic [WORD_W-1:0] fa, input logic [WORD_W-1:0] iv,
			input logic [WORD_W-1:0] tb, input logic [WORD_W-1:0] tc,
			input logic [WORD_W-1:0] lw);
		program_reg(REG_MIN_BATCH, mn);
		program_reg(REG_MAX_BATCH, mx);
		program_reg(REG_GROWTH_FACT, fa);
		program_reg(REG_GROWTH_INTV, iv);
		program_reg(REG_TIMEOUT_BASE, tb);
		program_reg(REG_TIMEOUT_CAP, tc);
		program_reg(REG_LOW_WATER, lw);
	endtask

	task automatic settle(input int tail);
		while (pending_words.size() != 0 || presenting || due_outcomes.size() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// mostly ascending ranges and time stamps; noise words carry arbitrary values
	task automatic gen_traffic(input int n, input int fill_pct, input int noise_pct);
		word_t w;
		logic [63:0] len;
		int r, k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 3))
				0: ;
				1: stamp_now += 64'($urandom_range(0, 1000));
				2: stamp_now += 64'(cf_intv) + 64'($urandom_range(0, 2));
				default: stamp_now += 64'($urandom);
			endcase
			w.stamp = stamp_now[ID_W-1:0];
			w.renew = 1'($urandom_range(0, 1));
			w.lo = rand_id();
			w.hi = rand_id();
			r = $urandom_range(0, 99);
			if (r < noise_pct) begin
				w.fn = 2'($urandom_range(0, 3));
				if ($urandom_range(0, 1) == 0)
					w.stamp = rand_id();
			end else if (r < noise_pct + fill_pct) begin
				w.fn = FN_FILL;
				id_base += 64'($urandom_range(0, 3));
				len = 64'($urandom_range(0, 6));
				w.lo = id_base[ID_W-1:0];
				if ($urandom_range(0, 7) == 0)
					w.hi = ID_W'(id_base - len);
				else
					w.hi = ID_W'(id_base + len);
				id_base += len + 1;
			end else if (r < noise_pct + fill_pct + 8) begin
				w.fn = FN_FAIL;
			end else if (r < noise_pct + fill_pct + 10) begin
				w.fn = FN_UNUSED;
			end else begin
				w.fn = FN_GET;
			end
			pending_words.push_back(w);
		end
	endtask

	initial begin : run
		int i, p;
		for (i = 0; i < RING_DEPTH; i++) begin
			ring_next[i] = '0;
			ring_lim[i] = '0;
		end
		rd_cnt = '0;
		wr_cnt = '0;
		req_open = 1'b0;
		retries = '0;
		grown_at = '0;
		cf_min = MIN_BATCH_RST;
		cf_max = MAX_BATCH_RST;
		cf_fact = GROWTH_FACT_RST;
		cf_intv = GROWTH_INTV_RST;
		cf_tbase = TIMEOUT_BASE_RST;
		cf_tcap = TIMEOUT_CAP_RST;
		cf_lw = LOW_WATER_RST;
		batch = 64'(MIN_BATCH_RST);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty ring, pending request, unused code, retries, skips and a full ring
		queue_word(FN_GET, '0, '0, 63'd5, 1'b1);
		queue_word(FN_GET, ID_MAX, ID_MAX, ID_MAX, 1'b1);
		queue_word(FN_UNUSED, ID_MAX, ID_MAX, ID_MAX, 1'b1);
		queue_word(FN_FAIL, ID_MAX, ID_MAX, ID_MAX, 1'b1);
		queue_word(FN_GET, '0, '0, 63'd6, 1'b0);
		queue_word(FN_FILL, '0, '0, '0, 1'b0);
		queue_word(FN_FILL, 63'd20, 63'd21, 63'd6, 1'b0);
		queue_word(FN_FILL, 63'd30, 63'd25, 63'd6, 1'b0);
		queue_word(FN_FILL, 63'd40, 63'd41, 63'd6, 1'b0);
		queue_word(FN_GET, '0, '0, 63'd7, 1'b0);
		queue_word(FN_GET, '0, '0, 63'd2000000, 1'b1);
		queue_word(FN_GET, '0, '0, 63'd2000001, 1'b0);
		for (i = 0; i < RING_DEPTH - 1; i++)
			queue_word(FN_FILL, 63'(100 + 10 * i), 63'(103 + 10 * i), 63'd2000002, 1'b0);
		queue_word(FN_FILL, ID_MAX, ID_MAX, 63'd2000002, 1'b0);
		stamp_now = 64'd2000002;
		settle(8);

		gen_traffic(140, 30, 0);
		settle(8);
		program_all(32'd1, 32'd1, 32'd1, 32'd0, 32'd1, 32'd1, 32'd1);
		gen_traffic(120, 25, 0);
		settle(8);
		program_all(32'd1048576, 32'd1073741824, 32'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'd255);
		gen_traffic(120, 40, 0);
		for (p = 0; p < 2; p++) begin
			settle(8);
			program_all({11'($urandom), 21'($urandom_range(1, 5000))},
				{1'($urandom), 31'($urandom_range(1, 1 << 20))},
				{27'($urandom), 5'($urandom_range(1, 16))},
				32'($urandom_range(0, 200000)),
				32'($urandom_range(1, 1 << 24)),
				$urandom,
				{24'($urandom), 8'($urandom_range(1, 8))});
			gen_traffic(120, $urandom_range(15, 45), 0);
		end
		settle(8);
		// zero batch step and factor, full-width values with upper bits set
		program_all(32'hFFE0_0000, 32'hFFFF_FFFF, 32'hFFFF_FFE0, 32'd0, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'hFFFF_FF05);
		program_reg(CFG_IDX_SPARE, $urandom);
		gen_traffic(100, 30, 0);
		settle(8);
		program_reg(REG_LOW_WATER, 32'd0);
		gen_traffic(40, 30, 0);
		settle(8);
		program_all(32'(MIN_BATCH_RST), 32'(MAX_BATCH_RST), 32'(GROWTH_FACT_RST),
			GROWTH_INTV_RST, TIMEOUT_BASE_RST, TIMEOUT_CAP_RST, 32'(LOW_WATER_RST));
		gen_traffic(100, 30, 25);
		while (pending_words.size() != 0)
			@(negedge clk);
		idle_on = 1'b0;
		gen_traffic(90, 30, 5);
		queue_word(FN_GET, ID_MAX, ID_MAX, ID_MAX, 1'b1);
		queue_word(FN_FILL, ID_MAX, ID_MAX, ID_MAX, 1'b1);
		queue_word(FN_GET, ID_MAX, ID_MAX, ID_MAX, 1'b0);
		settle(50);

		$display("run covered %0d words and %0d results: %0d ids, %0d empty gets, %0d skips",
			n_words, n_results, n_ids, n_none, n_skip);
		$display("refill requests %0d, batch growths %0d, dropped fills %0d, register writes %0d",
			n_req, n_grow, n_drop, n_cfg);
		if (n_bad == 0 && due_outcomes.size() == 0)
			$display("id_range_ring_dispenser_tb: done, clean");
		else
			$display("id_range_ring_dispenser_tb: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
sv/irrd_pkg.sv
sv/irrd_ram.sv
sv/irrd_ctrl.sv
sv/irrd_dp.sv
sv/id_range_ring_dispenser.sv
tb/sv/id_range_ring_dispenser_tb.sv
